// File: rtl/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

   // Default geometry: 1024 frames of 4 MiB
   localparam int FRAME_COUNT_DEF     = 1024;
   localparam int FRAME_SIZE_LOG2_DEF = 22;

   // Fixed field widths
   localparam int OP_W        = 3;
   localparam int ADDR_W      = 64;
   localparam int REL_W       = 10;
   localparam int RLF_W       = 11;
   localparam int FRAME_NUM_W = 10;
   localparam int COUNT_OUT_W = 11;
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 48;

   localparam logic [RLF_W-1:0] RLF_RESET = 11'd6;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 3'd0,
      OP_MARK    = 3'd1,
      OP_RESLOW  = 3'd2,
      OP_ALLOC   = 3'd3,
      OP_RELEASE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      FS_UNAVAIL   = 2'd0,
      FS_FREE      = 2'd1,
      FS_RESERVED  = 2'd2,
      FS_ALLOCATED = 2'd3
   } frame_state_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_RESP
   } engine_state_type;

   // Count update for one frame transition
   typedef struct packed {
      logic            clear;
      logic            en;
      frame_state_type old_st;
      frame_state_type new_st;
   } count_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/pfa_ram.sv
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/pfa_counters.sv
`default_nettype none

module pfa_counters #(
   parameter int FRAME_COUNT = pfa_pkg::FRAME_COUNT_DEF,
   localparam int CW = $clog2(FRAME_COUNT + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pfa_pkg::count_ctrl_type count_ctrl,
   output logic      [CW-1:0]           free_cnt,
   output logic      [CW-1:0]           reserved_cnt,
   output logic      [CW-1:0]           allocated_cnt
);

   import pfa_pkg::*;

   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] res_ff, res_in;
   logic [CW-1:0] alloc_ff, alloc_in;

   // old state leaves its bucket, new state joins its bucket
   always_comb begin
      free_in  = free_ff;
      res_in   = res_ff;
      alloc_in = alloc_ff;
      if (count_ctrl.clear) begin
         free_in  = '0;
         res_in   = '0;
         alloc_in = '0;
      end else if (count_ctrl.en) begin
         free_in  = free_ff + CW'(count_ctrl.new_st == FS_FREE)
                            - CW'(count_ctrl.old_st == FS_FREE);
         res_in   = res_ff + CW'(count_ctrl.new_st == FS_RESERVED)
                           - CW'(count_ctrl.old_st == FS_RESERVED);
         alloc_in = alloc_ff + CW'(count_ctrl.new_st == FS_ALLOCATED)
                             - CW'(count_ctrl.old_st == FS_ALLOCATED);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '0;
         res_ff   <= '0;
         alloc_ff <= '0;
      end else begin
         free_ff  <= free_in;
         res_ff   <= res_in;
         alloc_ff <= alloc_in;
      end
   end

   assign free_cnt      = free_ff;
   assign reserved_cnt  = res_ff;
   assign allocated_cnt = alloc_ff;

`ifndef ASSERT_OFF
   // the buckets together never hold more frames than the table has
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      ({2'b00, free_ff} + {2'b00, res_ff} + {2'b00, alloc_ff}) <= (CW+2)'(FRAME_COUNT))
      else $error("frame counts exceed table size");
`endif

endmodule

`default_nettype wire

// File: rtl/pfa_engine.sv
`default_nettype none

module pfa_engine #(
   parameter int FRAME_COUNT     = pfa_pkg::FRAME_COUNT_DEF,
   parameter int FRAME_SIZE_LOG2 = pfa_pkg::FRAME_SIZE_LOG2_DEF,
   localparam int IW = $clog2(FRAME_COUNT)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request side
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire pfa_pkg::op_type                  req_op,
   input  wire logic [pfa_pkg::ADDR_W-1:0]       req_base,
   input  wire logic [pfa_pkg::ADDR_W-1:0]       req_length,
   input  wire logic                             req_is_free,
   input  wire logic [pfa_pkg::REL_W-1:0]        req_release,
   input  wire logic [pfa_pkg::RLF_W-1:0]        rlf,
   // result side
   input  wire logic                             rsp_slot_free,
   output logic                                  rsp_load,
   output logic      [pfa_pkg::FRAME_NUM_W-1:0]  res_frame,
   output logic                                  res_failed,
   // counters
   output pfa_pkg::count_ctrl_type               count_ctrl,
   // frame table
   output logic                                  mem_we,
   output logic      [IW-1:0]                    mem_waddr,
   output logic      [1:0]                       mem_wdata,
   output logic      [IW-1:0]                    mem_raddr,
   input  wire logic [1:0]                       mem_rdata
);

   import pfa_pkg::*;

   localparam logic [IW-1:0] LAST_FRAME = IW'(FRAME_COUNT - 1);

   engine_state_type state_ff, state_in;

   // latched request
   op_type              op_ff, op_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [ADDR_W-1:0]   length_ff, length_in;
   logic                is_free_ff, is_free_in;
   logic [REL_W-1:0]    rel_ff, rel_in;

   // walk control
   logic                clear_op_ff, clear_op_in;
   logic [IW-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [IW-1:0]       rd_addr_ff, rd_addr_in;
   logic [IW-1:0]       last_ff, last_in;
   logic                issuing_ff, issuing_in;
   logic                p1_valid_ff, p1_valid_in;
   logic [IW-1:0]       p1_addr_ff, p1_addr_in;
   logic                p1_last_ff, p1_last_in;
   logic [FRAME_NUM_W-1:0] frame_ff, frame_in;
   logic                failed_ff, failed_in;

   // region bounds
   logic [ADDR_W-1:0]   base_frame, len_frame;
   logic                mark_ok;
   logic [IW:0]         mark_sum;
   logic [IW-1:0]       mark_last;

   // reserve-low and release bounds
   logic                rlf_ok;
   logic [IW-1:0]       rlf_last;
   logic [IW+REL_W-1:0] rel_ext;
   logic                rel_ok;

   // read-modify-write stage
   frame_state_type     s1_old, s1_new;
   logic                s1_found, s1_fail, s1_write, walk_done;
   logic [IW+FRAME_NUM_W-1:0] p1_addr_ext;

   // region start and clamped end, in frames
   always_comb begin
      base_frame = base_ff >> FRAME_SIZE_LOG2;
      len_frame  = length_ff >> FRAME_SIZE_LOG2;
      mark_ok    = base_frame < ADDR_W'(FRAME_COUNT);
      mark_sum   = {1'b0, base_frame[IW-1:0]} + {1'b0, len_frame[IW-1:0]};
      if (len_frame >= ADDR_W'(FRAME_COUNT) || mark_sum > (IW+1)'(FRAME_COUNT - 1)) begin
         mark_last = LAST_FRAME;
      end else begin
         mark_last = mark_sum[IW-1:0];
      end
   end

   // reserve-low count saturates at the table size
   always_comb begin
      rlf_ok = rlf != '0;
      if (32'(rlf) >= 32'(FRAME_COUNT)) begin
         rlf_last = LAST_FRAME;
      end else begin
         rlf_last = IW'(32'(rlf) - 32'd1);
      end
      rel_ext = {IW'(0), rel_ff};
      rel_ok  = rel_ext < (IW+REL_W)'(FRAME_COUNT);
   end

   // new frame state from the entry just read
   always_comb begin
      s1_old   = frame_state_type'(mem_rdata);
      s1_new   = s1_old;
      s1_found = 1'b0;
      s1_fail  = 1'b0;
      unique case (op_ff)
         OP_MARK: begin
            if (!is_free_ff) begin
               s1_new = FS_RESERVED;
            end else if (s1_old == FS_UNAVAIL) begin
               s1_new = FS_FREE;
            end
         end
         OP_RESLOW: begin
            s1_new = FS_RESERVED;
         end
         OP_ALLOC: begin
            if (s1_old == FS_FREE) begin
               s1_new   = FS_ALLOCATED;
               s1_found = 1'b1;
            end else if (p1_last_ff) begin
               s1_fail = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (s1_old == FS_ALLOCATED) begin
               s1_new = FS_FREE;
            end else begin
               s1_fail = 1'b1;
            end
         end
         default: begin
            s1_new = s1_old;
         end
      endcase
      s1_write    = s1_new != s1_old;
      walk_done   = p1_valid_ff && (p1_last_ff || s1_found);
      p1_addr_ext = {FRAME_NUM_W'(0), p1_addr_ff};
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      base_in       = base_ff;
      length_in     = length_ff;
      is_free_in    = is_free_ff;
      rel_in        = rel_ff;
      clear_op_in   = clear_op_ff;
      sweep_addr_in = sweep_addr_ff;
      rd_addr_in    = rd_addr_ff;
      last_in       = last_ff;
      issuing_in    = issuing_ff;
      p1_valid_in   = 1'b0;
      p1_addr_in    = rd_addr_ff;
      p1_last_in    = rd_addr_ff == last_ff;
      frame_in      = frame_ff;
      failed_in     = failed_ff;

      req_ready  = 1'b0;
      rsp_load   = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = p1_addr_ff;
      mem_wdata  = FS_UNAVAIL;
      count_ctrl = '{clear: 1'b0, en: 1'b0, old_st: FS_UNAVAIL, new_st: FS_UNAVAIL};

      unique case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = FS_UNAVAIL;
            if (sweep_addr_ff == LAST_FRAME) begin
               sweep_addr_in = '0;
               clear_op_in   = 1'b0;
               state_in      = clear_op_ff ? ST_RESP : ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = req_op;
               base_in    = req_base;
               length_in  = req_length;
               is_free_in = req_is_free;
               rel_in     = req_release;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            frame_in   = '0;
            failed_in  = 1'b0;
            issuing_in = 1'b0;
            state_in   = ST_RESP;
            unique case (op_ff)
               OP_CLEAR: begin
                  count_ctrl.clear = 1'b1;
                  clear_op_in      = 1'b1;
                  sweep_addr_in    = '0;
                  state_in         = ST_SWEEP;
               end
               OP_MARK: begin
                  if (mark_ok) begin
                     rd_addr_in = base_frame[IW-1:0];
                     last_in    = mark_last;
                     issuing_in = 1'b1;
                     state_in   = ST_WALK;
                  end
               end
               OP_RESLOW: begin
                  if (rlf_ok) begin
                     rd_addr_in = '0;
                     last_in    = rlf_last;
                     issuing_in = 1'b1;
                     state_in   = ST_WALK;
                  end
               end
               OP_ALLOC: begin
                  rd_addr_in = '0;
                  last_in    = LAST_FRAME;
                  issuing_in = 1'b1;
                  state_in   = ST_WALK;
               end
               OP_RELEASE: begin
                  if (rel_ok) begin
                     rd_addr_in = rel_ext[IW-1:0];
                     last_in    = rel_ext[IW-1:0];
                     issuing_in = 1'b1;
                     state_in   = ST_WALK;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_WALK: begin
            // read side: one entry per cycle until the end frame, or until an allocate finds a free frame
            if (issuing_ff) begin
               p1_valid_in = !walk_done;
               if (walk_done || rd_addr_ff == last_ff) begin
                  issuing_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff + 1'b1;
               end
            end
            // write side: entry read last cycle
            if (p1_valid_ff) begin
               mem_we            = s1_write;
               mem_waddr         = p1_addr_ff;
               mem_wdata         = s1_new;
               count_ctrl.en     = s1_write;
               count_ctrl.old_st = s1_old;
               count_ctrl.new_st = s1_new;
            end
            if (walk_done) begin
               issuing_in = 1'b0;
               failed_in  = s1_fail;
               if (s1_found) begin
                  frame_in = p1_addr_ext[FRAME_NUM_W-1:0];
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_op_ff   <= 1'b0;
         sweep_addr_ff <= '0;
         issuing_ff    <= 1'b0;
         p1_valid_ff   <= 1'b0;
      end else begin
         clear_op_ff   <= clear_op_in;
         sweep_addr_ff <= sweep_addr_in;
         issuing_ff    <= issuing_in;
         p1_valid_ff   <= p1_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      base_ff    <= base_in;
      length_ff  <= length_in;
      is_free_ff <= is_free_in;
      rel_ff     <= rel_in;
      rd_addr_ff <= rd_addr_in;
      last_ff    <= last_in;
      p1_addr_ff <= p1_addr_in;
      p1_last_ff <= p1_last_in;
      frame_ff   <= frame_in;
      failed_ff  <= failed_in;
   end

   assign mem_raddr  = rd_addr_ff;
   assign res_frame  = frame_ff;
   assign res_failed = failed_ff;

`ifndef ASSERT_OFF
   // a walk write-back lands on the entry whose read was issued in the cycle before
   a_rmw_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && mem_we) |-> (mem_waddr == $past(mem_raddr)))
      else $error("write-back address does not match read address");

   // a read in flight exists only inside a walk
   a_p1_in_walk: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> (state_ff == ST_WALK))
      else $error("pipeline stage valid outside walk");

   // a result is never loaded over one that is still waiting
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_slot_free)
      else $error("result loaded into occupied output register");
`endif

endmodule

`default_nettype wire

// File: rtl/page_frame_allocator_top.sv
// Operation: mark region, reserve low and allocate walk the frames of their range in the table;
//   release walks one frame; clear sweeps the whole table; requests that walk nothing go
//   straight from setup to the result.
// Flow: one request at a time; a new request is taken only once the previous result has been
//   loaded into the output register, so a result still waiting there holds the next request.
// Reset: synchronous; afterwards a pass over the table clears it, with req_tready low.
`default_nettype none

module page_frame_allocator_top #(
   parameter int FRAME_COUNT     = pfa_pkg::FRAME_COUNT_DEF,
   parameter int FRAME_SIZE_LOG2 = pfa_pkg::FRAME_SIZE_LOG2_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [63:0] region_base, [127:64] region_length, [128] region_is_free,
   // [138:129] frame_to_release, [143:139] zero
   input  wire logic [pfa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [2:0] operation
   input  wire logic [pfa_pkg::OP_W-1:0]           req_tuser,
   // result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [9:0] frame_number, [10] failed, [21:11] free_count,
   // [32:22] reserved_count, [43:33] allocated_count, [47:44] zero
   output logic      [pfa_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration
   input  wire logic                               csr_we,
   input  wire logic [pfa_pkg::RLF_W-1:0]          csr_wdata
);

   import pfa_pkg::*;

   localparam int IW = $clog2(FRAME_COUNT);
   localparam int CW = $clog2(FRAME_COUNT + 1);

   logic [RLF_W-1:0]       rlf_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                   rsp_slot_free, rsp_load;
   logic [FRAME_NUM_W-1:0] res_frame;
   logic                   res_failed;
   count_ctrl_type         count_ctrl;
   logic [CW-1:0]          free_cnt, reserved_cnt, allocated_cnt;
   logic [CW+COUNT_OUT_W-1:0] free_ext, res_ext, alloc_ext;

   logic                   mem_we;
   logic [IW-1:0]          mem_waddr, mem_raddr;
   logic [1:0]             mem_wdata, mem_rdata;

   // reserve-low register
   always_ff @(posedge clock) begin
      if (reset) begin
         rlf_ff <= RLF_RESET;
      end else if (csr_we) begin
         rlf_ff <= csr_wdata;
      end
   end

   pfa_ram #(
      .WIDTH (2),
      .DEPTH (FRAME_COUNT)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   pfa_counters #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_counters (
      .clock         (clock),
      .reset         (reset),
      .count_ctrl    (count_ctrl),
      .free_cnt      (free_cnt),
      .reserved_cnt  (reserved_cnt),
      .allocated_cnt (allocated_cnt)
   );

   pfa_engine #(
      .FRAME_COUNT     (FRAME_COUNT),
      .FRAME_SIZE_LOG2 (FRAME_SIZE_LOG2)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_op        (op_type'(req_tuser)),
      .req_base      (req_tdata[63:0]),
      .req_length    (req_tdata[127:64]),
      .req_is_free   (req_tdata[128]),
      .req_release   (req_tdata[138:129]),
      .rlf           (rlf_ff),
      .rsp_slot_free (rsp_slot_free),
      .rsp_load      (rsp_load),
      .res_frame     (res_frame),
      .res_failed    (res_failed),
      .count_ctrl    (count_ctrl),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata)
   );

   // output register; counts reported modulo 2^11
   always_comb begin
      free_ext      = {COUNT_OUT_W'(0), free_cnt};
      res_ext       = {COUNT_OUT_W'(0), reserved_cnt};
      alloc_ext     = {COUNT_OUT_W'(0), allocated_cnt};
      rsp_slot_free = !rsp_valid_ff || rsp_tready;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000,
                         alloc_ext[COUNT_OUT_W-1:0],
                         res_ext[COUNT_OUT_W-1:0],
                         free_ext[COUNT_OUT_W-1:0],
                         res_failed,
                         res_frame};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: tb/page_frame_allocator_top_tb.sv
module page_frame_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfa_pkg::*;

   localparam int FRAME_COUNT = FRAME_COUNT_DEF;
   localparam int FRAME_SHIFT = FRAME_SIZE_LOG2_DEF;
   localparam logic [ADDR_W-1:0] OFFSET_MASK = (64'd1 << FRAME_SHIFT) - 64'd1;
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;
   // opcodes the block leaves undecoded
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_RELEASE + 1;
   localparam logic [OP_W-1:0] OP_SPARE_LAST = '1;
   localparam int MAX_GAP = 13;
   localparam int ITEMS_PER_PHASE = 84;
   localparam int PHASES = 6;
   // no handshake for this long means the block is stuck
   localparam int STALL_LIMIT = 8 * (FRAME_COUNT + 32);

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [REL_W-1:0]  rel_frame;
      logic              is_free;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] base;
   } req_item_type;

   // laid out as on rsp_tdata, lowest field last
   typedef struct packed {
      logic [COUNT_OUT_W-1:0] allocated_count;
      logic [COUNT_OUT_W-1:0] reserved_count;
      logic [COUNT_OUT_W-1:0] free_count;
      logic                   failed;
      logic [FRAME_NUM_W-1:0] frame_number;
   } alloc_status_type;

   typedef struct {
      req_item_type     req;
      bit               typed;
      alloc_status_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [RLF_W-1:0] csr_wdata = '0;

   // shadow of the allocator
   frame_state_type frame_map [FRAME_COUNT];
   logic [COUNT_OUT_W-1:0] free_total;
   logic [COUNT_OUT_W-1:0] reserved_total;
   logic [COUNT_OUT_W-1:0] allocated_total;
   logic [RLF_W-1:0] low_frames;

   alloc_status_type awaited [$];
   bit rush = 1'b0;
   int mismatches = 0;
   int idle_cycles = 0;

   page_frame_allocator_top #(
      .FRAME_COUNT     (FRAME_COUNT),
      .FRAME_SIZE_LOG2 (FRAME_SHIFT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic int draw_gap();
      return rush ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // moves one frame to a new state and keeps the three counts in step
   function automatic void move_frame(input int idx, input frame_state_type st);
      case (frame_map[idx])
         FS_FREE:      free_total--;
         FS_RESERVED:  reserved_total--;
         FS_ALLOCATED: allocated_total--;
         default: ;
      endcase
      frame_map[idx] = st;
      case (st)
         FS_FREE:      free_total++;
         FS_RESERVED:  reserved_total++;
         FS_ALLOCATED: allocated_total++;
         default: ;
      endcase
   endfunction

   // applies one request to the shadow table, returns the status it reports
   function automatic alloc_status_type apply_request(input req_item_type r);
      alloc_status_type st;
      logic [ADDR_W-1:0] first_f;
      logic [ADDR_W-1:0] last_f;
      int n;
      st = '0;
      case (r.op)
         OP_CLEAR: begin
            foreach (frame_map[i]) frame_map[i] = FS_UNAVAIL;
            free_total = '0;
            reserved_total = '0;
            allocated_total = '0;
         end
         OP_MARK: begin
            first_f = r.base >> FRAME_SHIFT;
            last_f = first_f + (r.length >> FRAME_SHIFT);
            // a region starting past the table marks nothing
            if (first_f < FRAME_COUNT) begin
               if (last_f > FRAME_COUNT - 1) last_f = FRAME_COUNT - 1;
               for (int i = int'(first_f); i <= int'(last_f); i++) begin
                  if (!r.is_free) move_frame(i, FS_RESERVED);
                  else if (frame_map[i] == FS_UNAVAIL) move_frame(i, FS_FREE);
               end
            end
         end
         OP_RESLOW: begin
            n = (low_frames > FRAME_COUNT) ? FRAME_COUNT : int'(low_frames);
            for (int i = 0; i < n; i++) move_frame(i, FS_RESERVED);
         end
         OP_ALLOC: begin
            st.failed = 1'b1;
            for (int i = 0; i < FRAME_COUNT; i++) begin
               if (frame_map[i] == FS_FREE) begin
                  move_frame(i, FS_ALLOCATED);
                  st.frame_number = FRAME_NUM_W'(i);
                  st.failed = 1'b0;
                  break;
               end
            end
         end
         OP_RELEASE: begin
            if (r.rel_frame < FRAME_COUNT && frame_map[r.rel_frame] == FS_ALLOCATED)
               move_frame(int'(r.rel_frame), FS_FREE);
            else
               st.failed = 1'b1;
         end
         default: ;
      endcase
      st.free_count = free_total;
      st.reserved_count = reserved_total;
      st.allocated_count = allocated_total;
      return st;
   endfunction

   // every field random; callers narrow the ones their opcode uses
   function automatic req_item_type scrambled_request(input logic [OP_W-1:0] op);
      req_item_type r;
      r.op = op;
      r.base = {$urandom, $urandom};
      r.length = {$urandom, $urandom};
      r.is_free = 1'($urandom);
      r.rel_frame = REL_W'($urandom);
      return r;
   endfunction

   function automatic plan_row_type plan_row(input logic [OP_W-1:0] op,
                                             input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] length,
                                             input bit is_free, input int rel,
                                             input bit typed = 1'b0, input int frame = 0,
                                             input bit failed = 1'b0, input int free_n = 0,
                                             input int resv_n = 0, input int alloc_n = 0);
      plan_row_type row;
      row.req.op = op;
      row.req.base = base;
      row.req.length = length;
      row.req.is_free = is_free;
      row.req.rel_frame = REL_W'(rel);
      row.typed = typed;
      row.want.frame_number = FRAME_NUM_W'(frame);
      row.want.failed = failed;
      row.want.free_count = COUNT_OUT_W'(free_n);
      row.want.reserved_count = COUNT_OUT_W'(resv_n);
      row.want.allocated_count = COUNT_OUT_W'(alloc_n);
      return row;
   endfunction

   // drive one request, wait for the handshake, queue its expected status
   task automatic send_request(input req_item_type r, input bit typed = 1'b0,
                               input alloc_status_type typed_st = '0);
      int gap;
      alloc_status_type predicted;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= {{(REQ_TDATA_W - 2 * ADDR_W - 1 - REL_W){1'b0}},
                    r.rel_frame, r.is_free, r.length, r.base};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = apply_request(r);
      awaited.push_back(typed ? typed_st : predicted);
   endtask

   // let the block go idle, then load a new reserve-low count
   task automatic set_low_frames(input logic [RLF_W-1:0] value);
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      low_frames = value;
   endtask

   // result side: random back-pressure, then compare against the oldest expectation
   initial begin : result_sink
      int stall;
      int result_idx;
      alloc_status_type got;
      alloc_status_type want;
      result_idx = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            // hold off until a result is actually offered, then stall on it
            rsp_tready <= 1'b0;
            do @(posedge clock); while (rsp_tvalid !== 1'b1);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1));
         got = rsp_tdata[$bits(alloc_status_type)-1:0];
         if (awaited.size() == 0) begin
            note_mismatch($sformatf("result %0d arrived with nothing awaited", result_idx));
         end else begin
            want = awaited.pop_front();
            if (got.frame_number !== want.frame_number)
               note_mismatch($sformatf("result %0d frame_number %0d, want %0d",
                                       result_idx, got.frame_number, want.frame_number));
            if (got.failed !== want.failed)
               note_mismatch($sformatf("result %0d failed %0b, want %0b",
                                       result_idx, got.failed, want.failed));
            if (got.free_count !== want.free_count)
               note_mismatch($sformatf("result %0d free_count %0d, want %0d",
                                       result_idx, got.free_count, want.free_count));
            if (got.reserved_count !== want.reserved_count)
               note_mismatch($sformatf("result %0d reserved_count %0d, want %0d",
                                       result_idx, got.reserved_count, want.reserved_count));
            if (got.allocated_count !== want.allocated_count)
               note_mismatch($sformatf("result %0d allocated_count %0d, want %0d",
                                       result_idx, got.allocated_count, want.allocated_count));
         end
         result_idx++;
      end
   end

   // stuck detector: any handshake restarts the count
   always @(posedge clock) begin
      if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type directed_plan [$];
      logic [RLF_W-1:0] low_settings [PHASES];
      req_item_type next_req;
      int held [$];
      int phase_items;
      int regions;
      int ops;
      int pick;

      // shadow starts in the post-reset state
      foreach (frame_map[i]) frame_map[i] = FS_UNAVAIL;
      free_total = '0;
      reserved_total = '0;
      allocated_total = '0;
      low_frames = RLF_RESET;

      // directed: empty table, error paths, clamping, both ends of the table
      directed_plan.push_back(plan_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b1, 0, 1'b1));
      directed_plan.push_back(plan_row(OP_RELEASE, 0, 0, 1'b0, 0, 1'b1, 0, 1'b1));
      directed_plan.push_back(plan_row(OP_RELEASE, 0, 0, 1'b0, FRAME_COUNT - 1,
                                       1'b1, 0, 1'b1));
      directed_plan.push_back(plan_row(OP_RESLOW, 0, 0, 1'b0, 0, 1'b1, 0, 1'b0, 0, 6, 0));
      // free region over a reserved frame leaves it reserved
      directed_plan.push_back(plan_row(OP_MARK, 0, 0, 1'b1, 0, 1'b1, 0, 1'b0, 0, 6, 0));
      directed_plan.push_back(plan_row(OP_MARK, (64'd7 << FRAME_SHIFT) | OFFSET_MASK,
                                       (64'd3 << FRAME_SHIFT) | 64'd1, 1'b1, 0));
      directed_plan.push_back(plan_row(OP_MARK, ALL_ONES, ALL_ONES, 1'b0, FRAME_COUNT - 1));
      directed_plan.push_back(plan_row(OP_MARK, 64'(FRAME_COUNT - 1) << FRAME_SHIFT,
                                       ALL_ONES, 1'b1, 0));
      directed_plan.push_back(plan_row(OP_ALLOC, ALL_ONES, ALL_ONES, 1'b1, FRAME_COUNT - 1));
      directed_plan.push_back(plan_row(OP_ALLOC, 0, 0, 1'b0, 0));
      directed_plan.push_back(plan_row(OP_RELEASE, 0, 0, 1'b0, 7));
      directed_plan.push_back(plan_row(OP_RELEASE, 0, 0, 1'b0, 7));
      directed_plan.push_back(plan_row(OP_RELEASE, 0, 0, 1'b0, 9));
      directed_plan.push_back(plan_row(OP_RELEASE, 0, 0, 1'b0, 3));
      // reserved region over an allocated frame
      directed_plan.push_back(plan_row(OP_MARK, 64'd8 << FRAME_SHIFT, 0, 1'b0, 0));
      directed_plan.push_back(plan_row(OP_SPARE_FIRST, ALL_ONES, ALL_ONES, 1'b1,
                                       FRAME_COUNT - 1));
      directed_plan.push_back(plan_row(OP_SPARE_LAST, 0, 0, 1'b0, 0));
      directed_plan.push_back(plan_row(OP_MARK, 0, ALL_ONES, 1'b1, 0));
      directed_plan.push_back(plan_row(OP_RESLOW, 0, 0, 1'b0, 0));
      directed_plan.push_back(plan_row(OP_ALLOC, 0, 0, 1'b0, 0));
      directed_plan.push_back(plan_row(OP_CLEAR, ALL_ONES, ALL_ONES, 1'b1,
                                       FRAME_COUNT - 1, 1'b1));
      directed_plan.push_back(plan_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b1, 0, 1'b1));
      // first frame past the table: nothing marked
      directed_plan.push_back(plan_row(OP_MARK, 64'(FRAME_COUNT) << FRAME_SHIFT,
                                       64'd5 << FRAME_SHIFT, 1'b1, 0, 1'b1));
      directed_plan.push_back(plan_row(OP_MARK,
                                       (64'(FRAME_COUNT - 1) << FRAME_SHIFT) | OFFSET_MASK,
                                       0, 1'b1, 0, 1'b1, 0, 1'b0, 1, 0, 0));
      directed_plan.push_back(plan_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b1, FRAME_COUNT - 1,
                                       1'b0, 0, 0, 1));

      low_settings[0] = '0;
      low_settings[1] = RLF_W'(FRAME_COUNT);
      low_settings[2] = '1;
      low_settings[3] = RLF_W'($urandom_range(2, FRAME_COUNT - 2));
      low_settings[4] = RLF_W'(1);
      low_settings[5] = RLF_W'(FRAME_COUNT - 1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part runs with the reset value of the reserve-low count
      foreach (directed_plan[i])
         send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         set_low_frames(low_settings[phase]);
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            // session: optional clear, a memory map, maybe reserve low, then traffic
            rush = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) begin
               send_request(scrambled_request(OP_CLEAR));
               phase_items++;
            end
            regions = $urandom_range(1, 4);
            for (int k = 0; k < regions; k++) begin
               next_req = scrambled_request(OP_MARK);
               pick = $urandom_range(0, 19);
               if (pick < 14) begin
                  // short region inside the table, mostly usable memory
                  next_req.base = (64'($urandom_range(0, FRAME_COUNT - 1)) << FRAME_SHIFT) |
                                  (next_req.base & OFFSET_MASK);
                  next_req.length = (64'($urandom_range(0, 6)) << FRAME_SHIFT) |
                                    (next_req.length & OFFSET_MASK);
                  next_req.is_free = (pick < 11);
               end else if (pick < 17) begin
                  // huge length, clamped at the last frame
                  next_req.base = (64'($urandom_range(0, FRAME_COUNT - 1)) << FRAME_SHIFT) |
                                  (next_req.base & OFFSET_MASK);
               end else if ((next_req.base >> FRAME_SHIFT) < FRAME_COUNT) begin
                  next_req.base[ADDR_W-1] = 1'b1;
               end
               send_request(next_req);
               phase_items++;
            end
            if ($urandom_range(0, 1) == 0) begin
               send_request(scrambled_request(OP_RESLOW));
               phase_items++;
            end
            ops = $urandom_range(4, 14);
            for (int k = 0; k < ops; k++) begin
               pick = $urandom_range(0, 19);
               if (pick < 11) begin
                  send_request(scrambled_request(OP_ALLOC));
                  phase_items++;
               end else if (pick < 19) begin
                  next_req = scrambled_request(OP_RELEASE);
                  // mostly give back a frame that is really held
                  if (pick < 18) begin
                     held.delete();
                     foreach (frame_map[f]) if (frame_map[f] == FS_ALLOCATED) held.push_back(f);
                     if (held.size() != 0)
                        next_req.rel_frame = REL_W'(held[$urandom_range(0, held.size() - 1)]);
                  end
                  send_request(next_req);
                  phase_items++;
               end else begin
                  // undecoded opcode, ignored by the block
                  send_request(scrambled_request(OP_W'($urandom_range(OP_SPARE_FIRST,
                                                                       OP_SPARE_LAST))));
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      // catch any stray result
      repeat (FRAME_COUNT + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: page_frame_allocator_top.f
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_counters.sv
rtl/pfa_engine.sv
rtl/page_frame_allocator_top.sv
tb/page_frame_allocator_top_tb.sv
